// File: rtl/core/sbps_pkg.sv
// ----------------------------------------------------------------------------
// sbps_pkg
// Shared types and constants for the six-button pad scanner.
// ----------------------------------------------------------------------------
package sbps_pkg;

  // Configuration register widths and indexes
  localparam int CFG_W       = 16;
  localparam int CFG_ADDR_W  = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_READ_DELAY = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAP_DELAY  = 1'd1;

  localparam logic [CFG_W-1:0] READ_DELAY_RST = 16'd20;
  localparam logic [CFG_W-1:0] GAP_DELAY_RST  = 16'd1000;

  // Scan phases: 0..7 scan, 8 idle
  localparam int PHASE_W = 4;
  localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd0;
  localparam logic [PHASE_W-1:0] PHASE_DIRS  = 4'd1;
  localparam logic [PHASE_W-1:0] PHASE_SIX   = 4'd4;
  localparam logic [PHASE_W-1:0] PHASE_XYZ   = 4'd5;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 4'd7;
  localparam logic [PHASE_W-1:0] PHASE_IDLE  = 4'd8;

  // Button bit positions
  localparam int BTN_W     = 12;
  localparam int BTN_UP    = 0;
  localparam int BTN_DOWN  = 1;
  localparam int BTN_LEFT  = 2;
  localparam int BTN_RIGHT = 3;
  localparam int BTN_A     = 4;
  localparam int BTN_B     = 5;
  localparam int BTN_C     = 6;
  localparam int BTN_START = 7;
  localparam int BTN_X     = 8;
  localparam int BTN_Y     = 9;
  localparam int BTN_Z     = 10;
  localparam int BTN_MODE  = 11;

  typedef struct packed {
    logic pin1_level;
    logic pin2_level;
    logic pin3_level;
    logic pin4_level;
    logic pin6_level;
    logic pin9_level;
  } in_item_t;

  typedef struct packed {
    logic             select_level;
    logic [BTN_W-1:0] buttons;
    logic             pad_present;
    logic             six_button;
    logic             scan_done;
  } out_item_t;

  // Sequencer to button decoder: sample strobe for the current tick
  typedef struct packed {
    logic               sample;
    logic [PHASE_W-1:0] phase;
    logic               done;
  } seq_ctl_t;

endpackage

// File: rtl/core/sbps_seq.sv
// ----------------------------------------------------------------------------
// sbps_seq
// Phase and tick sequencer: walks select through eight phases, then idles.
// ----------------------------------------------------------------------------
module sbps_seq import sbps_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [CFG_W-1:0] read_delay,
  input  logic [CFG_W-1:0] gap_delay,
  output seq_ctl_t         ctl,
  output logic             select_nxt
);

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic [PHASE_W-1:0]    phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  select_r;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  gap_hit, rd_hit, is_idle;

  assign is_idle   = phase_r[PHASE_W-1];
  assign count_inc = (&count_r) ? count_r : count_r + 1'b1;
  // saturated count counts as reaching any delay
  assign gap_hit   = (CMP_W'(count_r) >= CMP_W'(gap_delay)) || (&count_r);
  assign rd_hit    = (CMP_W'(count_inc) >= CMP_W'(read_delay)) || (&count_inc);

  // next state for one tick
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    select_nxt = select_r;
    ctl.sample = 1'b0;
    ctl.phase  = phase_r;
    ctl.done   = 1'b0;
    if (is_idle) begin
      if (gap_hit) begin
        phase_nxt  = PHASE_FIRST;
        select_nxt = 1'b0;
        count_nxt  = '0;
      end else begin
        count_nxt  = count_r + 1'b1;
      end
    end else if (rd_hit) begin
      ctl.sample = 1'b1;
      count_nxt  = '0;
      if (phase_r == PHASE_LAST) begin
        phase_nxt  = PHASE_IDLE;
        select_nxt = 1'b1;
        ctl.done   = 1'b1;
      end else begin
        phase_nxt  = phase_r + 1'b1;
        select_nxt = phase_nxt[0];
      end
    end else begin
      count_nxt = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PHASE_IDLE;
      count_r  <= '0;
      select_r <= 1'b1;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      select_r <= select_nxt;
    end
  end

endmodule

// File: rtl/core/sbps_btn.sv
// ----------------------------------------------------------------------------
// sbps_btn
// Button decoder: updates button, pad-present and six-button flags on samples.
// ----------------------------------------------------------------------------
module sbps_btn import sbps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  seq_ctl_t         ctl,
  input  in_item_t         pins,
  output logic [BTN_W-1:0] buttons_nxt,
  output logic             present_nxt,
  output logic             six_nxt
);

  logic [BTN_W-1:0] buttons_r;
  logic             present_r, six_r;
  logic             p1, p2, p3, p4, p6, p9;
  logic             en6;

  // pull-ups: low level means pressed
  assign p1 = ~pins.pin1_level;
  assign p2 = ~pins.pin2_level;
  assign p3 = ~pins.pin3_level;
  assign p4 = ~pins.pin4_level;
  assign p6 = ~pins.pin6_level;
  assign p9 = ~pins.pin9_level;

  assign en6 = present_r & six_r;

  always_comb begin
    buttons_nxt = buttons_r;
    present_nxt = present_r;
    six_nxt     = six_r;
    if (ctl.sample) begin
      case (ctl.phase)
        PHASE_FIRST: begin
          present_nxt = p3 & p4;
          if (p3 & p4) begin
            buttons_nxt[BTN_A]     = p6;
            buttons_nxt[BTN_START] = p9;
          end
        end
        PHASE_DIRS: begin
          buttons_nxt[BTN_UP]    = present_r & p1;
          buttons_nxt[BTN_DOWN]  = present_r & p2;
          buttons_nxt[BTN_LEFT]  = present_r & p3;
          buttons_nxt[BTN_RIGHT] = present_r & p4;
          buttons_nxt[BTN_B]     = present_r & p6;
          buttons_nxt[BTN_C]     = present_r & p9;
        end
        PHASE_SIX: begin
          six_nxt = present_r & p1 & p2;
        end
        PHASE_XYZ: begin
          buttons_nxt[BTN_Z]    = en6 & p1;
          buttons_nxt[BTN_Y]    = en6 & p2;
          buttons_nxt[BTN_X]    = en6 & p3;
          buttons_nxt[BTN_MODE] = en6 & p4;
        end
        default: begin
          buttons_nxt = buttons_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buttons_r <= '0;
      present_r <= 1'b0;
      six_r     <= 1'b0;
    end else if (advance) begin
      buttons_r <= buttons_nxt;
      present_r <= present_nxt;
      six_r     <= six_nxt;
    end
  end

endmodule

// File: rtl/core/six_button_pad_scanner.sv
// ----------------------------------------------------------------------------
// six_button_pad_scanner
// Scans a six-button DB9 pad through a multiplexed select line.
// ----------------------------------------------------------------------------
// Each input beat is one tick (about 1 us) of the six pad pin levels and
// yields exactly one result beat: the select level to drive from that tick
// on, the 12 button bits, pad-present, six-button and a one-tick scan-done
// flag. A beat passes through two registers (input register, then result
// register) and one beat is accepted every cycle; the only stalls come from
// out_ready being low. read_delay and gap_delay are counted in beats, not
// clock cycles; write them only while no beat is in flight.
module six_button_pad_scanner import sbps_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic [CFG_W-1:0] read_delay_r, gap_delay_r;
  logic             s1_valid_r;
  in_item_t         s1_item_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  logic             advance;
  seq_ctl_t         ctl;
  logic             select_nxt, present_nxt, six_nxt;
  logic [BTN_W-1:0] buttons_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_delay_r <= READ_DELAY_RST;
      gap_delay_r  <= GAP_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_READ_DELAY: read_delay_r <= cfg_wdata;
        CFG_GAP_DELAY:  gap_delay_r  <= cfg_wdata;
        default: begin
          read_delay_r <= read_delay_r;
        end
      endcase
    end
  end

  // handshake: the result register frees up when empty or being taken
  assign advance  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  sbps_seq #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .read_delay (read_delay_r),
    .gap_delay  (gap_delay_r),
    .ctl        (ctl),
    .select_nxt (select_nxt)
  );

  sbps_btn u_btn (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .ctl         (ctl),
    .pins        (s1_item_r),
    .buttons_nxt (buttons_nxt),
    .present_nxt (present_nxt),
    .six_nxt     (six_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.select_level <= select_nxt;
      out_item_r.buttons      <= buttons_nxt;
      out_item_r.pad_present  <= present_nxt;
      out_item_r.six_button   <= six_nxt;
      out_item_r.scan_done    <= ctl.done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// File: verif/pad_scan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pad_scan_checker
// Watches the tick and result channels of the pad scanner, keeps its own copy
// of the scan sequencer and button decoder, and compares every result beat
// with the oldest prediction. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module pad_scan_checker import sbps_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    beats_checked,
  output int                    scans_seen,
  output int                    pad_scans,
  output int                    six_scans
);

  localparam logic [COUNT_BITS-1:0] TICK_SAT = {COUNT_BITS{1'b1}};
  localparam int MAX_PRINTS = 25;

  // Shadow registers and scanner state
  logic [CFG_W-1:0]      read_ticks;
  logic [CFG_W-1:0]      gap_ticks;
  logic [PHASE_W-1:0]    scan_phase;
  logic [COUNT_BITS-1:0] tick_cnt;
  logic                  sel_lvl;
  logic [BTN_W-1:0]      btn_bits;
  logic                  pad_seen;
  logic                  six_seen;

  // Predicted result beats, oldest first
  out_item_t due_reports[$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    beats_checked = 0;
    scans_seen    = 0;
    pad_scans     = 0;
    six_scans     = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("[%0t] result beat %0d: %s got 0x%0h, expected 0x%0h",
               $time, beats_checked, what, got_v, want_v);
  endtask

  // A saturated count has reached any delay
  function automatic logic count_hit(input logic [COUNT_BITS-1:0] cnt,
                                     input logic [CFG_W-1:0] target);
    return (cnt >= target) || (cnt == TICK_SAT);
  endfunction

  // Decode the pins sampled at the end of the current phase
  task automatic latch_pins(input in_item_t pins);
    logic p1, p2, p3, p4, p6, p9;
    logic xyz_ok;
    p1 = ~pins.pin1_level;
    p2 = ~pins.pin2_level;
    p3 = ~pins.pin3_level;
    p4 = ~pins.pin4_level;
    p6 = ~pins.pin6_level;
    p9 = ~pins.pin9_level;
    case (scan_phase)
      PHASE_FIRST: begin
        // pad pulls 3 and 4 low; without a pad A and Start hold
        pad_seen = p3 & p4;
        if (pad_seen) begin
          btn_bits[BTN_A]     = p6;
          btn_bits[BTN_START] = p9;
        end
      end
      PHASE_DIRS: begin
        btn_bits[BTN_UP]    = pad_seen & p1;
        btn_bits[BTN_DOWN]  = pad_seen & p2;
        btn_bits[BTN_LEFT]  = pad_seen & p3;
        btn_bits[BTN_RIGHT] = pad_seen & p4;
        btn_bits[BTN_B]     = pad_seen & p6;
        btn_bits[BTN_C]     = pad_seen & p9;
      end
      PHASE_SIX: six_seen = pad_seen & p1 & p2;
      PHASE_XYZ: begin
        xyz_ok = pad_seen & six_seen;
        btn_bits[BTN_Z]    = xyz_ok & p1;
        btn_bits[BTN_Y]    = xyz_ok & p2;
        btn_bits[BTN_X]    = xyz_ok & p3;
        btn_bits[BTN_MODE] = xyz_ok & p4;
      end
      default: ;
    endcase
  endtask

  // Advance the scanner by one tick and form its result beat
  task automatic scan_tick(input in_item_t pins, output out_item_t res);
    logic [COUNT_BITS-1:0] nxt;
    logic                  done;
    done = 1'b0;
    if (scan_phase >= PHASE_IDLE) begin
      if (count_hit(tick_cnt, gap_ticks)) begin
        scan_phase = PHASE_FIRST;
        sel_lvl    = 1'b0;
        tick_cnt   = '0;
      end else begin
        tick_cnt = tick_cnt + 1'b1;
      end
    end else begin
      nxt = (tick_cnt == TICK_SAT) ? TICK_SAT : tick_cnt + 1'b1;
      if (count_hit(nxt, read_ticks)) begin
        latch_pins(pins);
        tick_cnt = '0;
        if (scan_phase == PHASE_LAST) begin
          scan_phase = PHASE_IDLE;
          sel_lvl    = 1'b1;
          done       = 1'b1;
        end else begin
          scan_phase = scan_phase + 1'b1;
          sel_lvl    = scan_phase[0];
        end
      end else begin
        tick_cnt = nxt;
      end
    end
    res.select_level = sel_lvl;
    res.buttons      = btn_bits;
    res.pad_present  = pad_seen;
    res.six_button   = six_seen;
    res.scan_done    = done;
  endtask

  // Monitor: register writes, result compare, then prediction of new ticks
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      read_ticks = READ_DELAY_RST;
      gap_ticks  = GAP_DELAY_RST;
      scan_phase = PHASE_IDLE;
      tick_cnt   = '0;
      sel_lvl    = 1'b1;
      btn_bits   = '0;
      pad_seen   = 1'b0;
      six_seen   = 1'b0;
      due_reports.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_READ_DELAY: read_ticks = cfg_wdata;
          CFG_GAP_DELAY:  gap_ticks  = cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        got = out_data;
        if (due_reports.size() == 0) begin
          report_mismatch("unexpected beat, data", 32'(got), 0);
        end else begin
          want = due_reports.pop_front();
          if (got.select_level !== want.select_level)
            report_mismatch("select_level", 32'(got.select_level),
                            32'(want.select_level));
          if (got.buttons !== want.buttons)
            report_mismatch("buttons", 32'(got.buttons), 32'(want.buttons));
          if (got.pad_present !== want.pad_present)
            report_mismatch("pad_present", 32'(got.pad_present),
                            32'(want.pad_present));
          if (got.six_button !== want.six_button)
            report_mismatch("six_button", 32'(got.six_button),
                            32'(want.six_button));
          if (got.scan_done !== want.scan_done)
            report_mismatch("scan_done", 32'(got.scan_done),
                            32'(want.scan_done));
        end
        beats_checked++;
      end

      if (in_valid && in_ready) begin
        scan_tick(in_data, want);
        due_reports.push_back(want);
        if (want.scan_done) begin
          scans_seen++;
          if (want.pad_present) pad_scans++;
          if (want.six_button)  six_scans++;
        end
      end

      pending <= due_reports.size();
    end
  end

endmodule

// File: verif/tb_six_button_pad_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_six_button_pad_scanner
// Drives pad pin ticks into the scanner through bursts and gaps, stalls the
// result side on its own pattern (with one long hold-off), steps the delay
// registers through several settings and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_six_button_pad_scanner;
  import sbps_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIRECTED_N   = 22;

  // Stimulus flavors for a burst of ticks
  typedef enum int {PAD_SIX, PAD_THREE, PAD_NONE, PIN_NOISE} pad_kind_e;

  // Directed ticks with read delay 1 and no gap, so each tick ends a phase.
  // Pin order: 1 2 3 4 6 9.
  localparam logic [0:DIRECTED_N-1][5:0] DIRECTED = {
    // six-button pad, everything pressed
    6'b000000, 6'b000000, 6'b000000, 6'b000000, 6'b000000,
    6'b000000, 6'b000000, 6'b000000, 6'b000000,
    // pad present but three-button: X/Y/Z/Mode must clear
    6'b111111, 6'b110001, 6'b010110, 6'b111111, 6'b000000,
    6'b011111, 6'b000000, 6'b111111, 6'b101010,
    // no pad: A and Start hold, directions/B/C clear
    6'b000000, 6'b111111, 6'b000000, 6'b110011
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;

  int fail_count;
  int pending;
  int beats_checked;
  int scans_seen;
  int pad_scans;
  int six_scans;
  int beats_sent    = 0;
  int settings_used = 1;
  int cycle_count   = 0;
  bit held_off      = 1'b0;

  six_button_pad_scanner uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  pad_scan_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_checked (beats_checked),
    .scans_seen    (scans_seen),
    .pad_scans     (pad_scans),
    .six_scans     (six_scans)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped at cycle limit with %0d beats outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

  // Offer one tick beat and hold it until accepted
  task automatic send_beat(input in_item_t pins);
    in_valid <= 1'b1;
    in_data  <= pins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Pin levels for one tick; a pad pulls pins 3 and 4 low most of the time
  function automatic in_item_t make_pins(input pad_kind_e kind);
    in_item_t pins;
    pins = in_item_t'(6'($urandom_range(0, 63)));
    case (kind)
      PAD_SIX: begin
        pins.pin1_level = ($urandom_range(0, 3) == 0);
        pins.pin2_level = ($urandom_range(0, 3) == 0);
        pins.pin3_level = ($urandom_range(0, 7) == 0);
        pins.pin4_level = ($urandom_range(0, 7) == 0);
      end
      PAD_THREE: begin
        pins.pin1_level = ($urandom_range(0, 3) != 0);
        pins.pin2_level = ($urandom_range(0, 3) != 0);
        pins.pin3_level = ($urandom_range(0, 7) == 0);
        pins.pin4_level = ($urandom_range(0, 7) == 0);
      end
      PAD_NONE: begin
        pins.pin3_level = ($urandom_range(0, 5) != 0);
        pins.pin4_level = ($urandom_range(0, 5) != 0);
      end
      default: ;
    endcase
    return pins;
  endfunction

  // Random bursts of ticks separated by random gaps
  task automatic run_items(input int count);
    int        burst;
    int        gap;
    pad_kind_e kind;
    while (count > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                          : $urandom_range(1, 25);
      kind  = pad_kind_e'($urandom_range(0, 3));
      for (int k = 0; k < burst && count > 0; k++) begin
        send_beat(make_pins(kind));
        count--;
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Let every beat in flight drain, then write both delay registers
  task automatic apply_setting(input logic [CFG_W-1:0] read_ticks,
                               input logic [CFG_W-1:0] gap_ticks);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_READ_DELAY;
    cfg_wdata <= read_ticks;
    @(posedge clk);
    cfg_addr  <= CFG_GAP_DELAY;
    cfg_wdata <= gap_ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Result side: stall patterns, plus one long hold-off to back up the pipe
  initial begin : result_side
    int mode;
    int span;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && beats_sent >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      for (int k = 0; k < span; k++) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ((k % 5) != 4);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_READ_DELAY;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset delays: only idle counting within this short stretch
    run_items(40);

    // directed scans, one phase per tick
    apply_setting(16'd1, 16'd0);
    for (int i = 0; i < DIRECTED_N; i++)
      send_beat(in_item_t'(DIRECTED[i]));
    run_items(230);

    apply_setting(16'd2, 16'd3);
    run_items(250);
    apply_setting(16'd3, 16'd0);
    run_items(250);
    // zero read delay behaves as one
    apply_setting(16'd0, 16'd1);
    run_items(200);
    // largest delays: the counter only climbs here
    apply_setting(16'hFFFF, 16'hFFFF);
    run_items(150);
    apply_setting(16'd1, 16'd5);
    run_items(250);
    apply_setting(16'd6, 16'd17);
    run_items(250);
    apply_setting(16'd4, 16'd2);
    run_items(150);

    // drain
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d tick results over %0d delay settings", beats_checked,
             settings_used);
    $display("scans completed: %0d, with a pad: %0d, six-button: %0d",
             scans_seen, pad_scans, six_scans);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
